/* hw/rtl/round_robin_quantum_scheduler_core_assert.svh */
// Assertion macros shared by the scheduler RTL modules.
// Each macro expects signals named i_clk and i_rst_n in the module that uses it.
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_CORE_ASSERT_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_CORE_ASSERT_SVH

// A property that must hold in the same cycle, outside reset.
`define RRQS_ASSERT_NOW(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define RRQS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/rrqs_pkg.sv */
// Shared constants, types and helper functions of the round-robin scheduler.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package rrqs_pkg;

    localparam int MAX_JOBS = 16;
    localparam int SLOT_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    localparam int TICK_W   = 16;
    localparam int ID_W     = 8;
    localparam int ID_BASE  = 101;

    localparam logic [TICK_W-1:0] QUANTUM_RESET = TICK_W'(1);

    // Item kinds.
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [TICK_W-1:0] t_ticks;
    typedef logic [ID_W-1:0]   t_id;
    typedef logic [MAX_JOBS-1:0] t_mask;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // a word is taken from the input channel this cycle
        logic exec;      // run the selected job (the S_EXEC run step of a tick)
        logic load_out;  // load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tick_found;  // the presented word is a tick and some job is unfinished
    } t_sts;

    function automatic t_id slot_id(input t_slot slot);
        return ID_W'(ID_BASE) + ID_W'(slot);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/rrqs_ctrl.sv */
// Controller state machine of the round-robin scheduler.
// Depends on rrqs_pkg and the assertion header; drives commands to rrqs_dp.
`default_nettype none
`include "round_robin_quantum_scheduler_core_assert.svh"

module rrqs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire rrqs_pkg::t_sts i_sts,
    output rrqs_pkg::t_cmd     o_cmd
);
    import rrqs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.accept   = accept;
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.load_out = (accept && !i_sts.tick_found) || (r_state == S_EXEC);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_sts.tick_found) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `RRQS_ASSERT_NOW(a_no_overwrite, !o_cmd.load_out || !r_out_valid || i_out_ready,
        "result register loaded while a word is still held")
    `RRQS_ASSERT_NEXT(a_exec_one_cycle, r_state == S_EXEC, r_state == S_IDLE,
        "run step lasted longer than one cycle")
    `RRQS_ASSERT_NEXT(a_exec_loads, r_state == S_EXEC, r_out_valid,
        "run step did not present a result")

endmodule

`default_nettype wire

/* hw/rtl/rrqs_dp.sv */
// Datapath of the round-robin scheduler: slot memory, unfinished mask, pointers.
// Depends on rrqs_pkg and the assertion header; commanded by rrqs_ctrl.
`default_nettype none
`include "round_robin_quantum_scheduler_core_assert.svh"

module rrqs_dp (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire rrqs_pkg::t_cmd          i_cmd,
    output rrqs_pkg::t_sts               o_sts,
    input  wire logic                    i_kind,
    input  wire logic [rrqs_pkg::TICK_W-1:0] i_burst_ticks,
    input  wire logic                    i_cfg_we,
    input  wire logic [rrqs_pkg::TICK_W-1:0] i_cfg_wdata,
    output logic                         o_added,
    output logic [rrqs_pkg::ID_W-1:0]    o_assigned_id,
    output logic                         o_ran,
    output logic [rrqs_pkg::ID_W-1:0]    o_run_id,
    output logic                         o_run_finished,
    output logic                         o_pending
);
    import rrqs_pkg::*;

    // Slot memory: ticks left per job, valid only below the job count.
    t_ticks r_mem [MAX_JOBS];

    t_mask  r_mask, n_mask;      // bit set: slot in use and unfinished
    t_count r_job_count;
    t_slot  r_cur;
    t_ticks r_slice;
    t_ticks r_quantum;
    t_slot  r_slot;              // slot chosen for the running tick
    t_ticks r_rd;                // registered memory read of that slot

    logic   r_added, r_ran, r_fin, r_pend;
    t_id    r_aid, r_rid;

    logic   full, add_ok, wr_en, fin, end_turn, wrap;
    t_slot  add_slot, found, wr_addr, next_slot;
    t_ticks wr_data, rem, slice_inc, q_eff;

    // Circular first-set search starting at the current slot.
    function automatic t_slot first_from(input t_mask mask, input t_slot cur);
        logic [2*MAX_JOBS-1:0] dbl;
        t_mask                 rot;
        logic [SLOT_W:0]       pos;
        logic [SLOT_W:0]       sum;
        logic                  hit;
        dbl = {mask, mask} >> cur;
        rot = dbl[MAX_JOBS-1:0];
        pos = '0;
        hit = 1'b0;
        for (int i = 0; i < MAX_JOBS; i++) begin
            if (!hit && rot[i]) begin
                pos = (SLOT_W+1)'(i);
                hit = 1'b1;
            end
        end
        sum = {1'b0, cur} + pos;
        if (sum >= (SLOT_W+1)'(MAX_JOBS)) begin
            sum = sum - (SLOT_W+1)'(MAX_JOBS);
        end
        return sum[SLOT_W-1:0];
    endfunction

    assign full     = (r_job_count == CNT_W'(MAX_JOBS));
    assign add_slot = r_job_count[SLOT_W-1:0];
    assign add_ok   = i_cmd.accept && (i_kind == KIND_ADD) && !full;
    assign found    = first_from(r_mask, r_cur);

    assign o_sts.tick_found = (i_kind == KIND_TICK) && (|r_mask);

    // Run step arithmetic.
    assign rem       = r_rd - TICK_W'(1);
    assign fin       = (rem == '0);
    assign slice_inc = r_slice + TICK_W'(1);
    assign q_eff     = (r_quantum == '0) ? TICK_W'(1) : r_quantum;
    assign end_turn  = fin || (slice_inc >= q_eff);
    assign wrap      = (({1'b0, r_slot} + (SLOT_W+1)'(1)) == (SLOT_W+1)'(r_job_count));
    assign next_slot = wrap ? '0 : r_slot + SLOT_W'(1);

    assign wr_en   = add_ok || i_cmd.exec;
    assign wr_addr = i_cmd.exec ? r_slot : add_slot;
    assign wr_data = i_cmd.exec ? rem : i_burst_ticks;

    always_comb begin
        n_mask = r_mask;
        if (add_ok) begin
            n_mask[add_slot] = (i_burst_ticks != '0);
        end
        if (i_cmd.exec && fin) begin
            n_mask[r_slot] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.accept) begin
            r_rd   <= r_mem[found];
            r_slot <= found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_job_count <= '0;
            r_cur       <= '0;
            r_slice     <= '0;
            r_quantum   <= QUANTUM_RESET;
        end else begin
            r_mask <= n_mask;
            if (add_ok) begin
                r_job_count <= r_job_count + CNT_W'(1);
            end
            if (i_cmd.exec) begin
                r_cur   <= end_turn ? next_slot : r_slot;
                r_slice <= end_turn ? '0 : slice_inc;
            end
            if (i_cfg_we) begin
                r_quantum <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_added <= add_ok;
            r_aid   <= add_ok ? slot_id(add_slot) : '0;
            r_ran   <= i_cmd.exec;
            r_rid   <= i_cmd.exec ? slot_id(r_slot) : '0;
            r_fin   <= i_cmd.exec && fin;
            r_pend  <= |n_mask;
        end
    end

    assign o_added        = r_added;
    assign o_assigned_id  = r_aid;
    assign o_ran          = r_ran;
    assign o_run_id       = r_rid;
    assign o_run_finished = r_fin;
    assign o_pending      = r_pend;

    `RRQS_ASSERT_NOW(a_mask_in_use, (r_mask >> r_job_count) == '0,
        "unfinished bit set for a slot that is not in use")
    `RRQS_ASSERT_NOW(a_cur_in_range, r_job_count == '0 || CNT_W'(r_cur) < r_job_count,
        "current slot beyond the slots in use")
    `RRQS_ASSERT_NOW(a_count_bound, r_job_count <= CNT_W'(MAX_JOBS),
        "job count beyond table size")

endmodule

`default_nettype wire

/* hw/rtl/round_robin_quantum_scheduler_core.sv */
// Top level of the round-robin tick scheduler with a time quantum.
// Depends on rrqs_pkg, rrqs_ctrl and rrqs_dp.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_ready    i_kind, i_burst_ticks
//   result    out        o_out_valid / i_out_ready  o_added .. o_pending
//   config    in         i_cfg_we (no wait)         i_cfg_wdata (quantum)
//
// An add word is done when accepted; a tick then needs the S_EXEC run step,
// set by the registered read of the slot memory after the rotating search.
// Reset is synchronous and active low; it clears the job count, the unfinished
// mask, the slot pointer and the slice counter and sets the quantum to one.
// The slot memory is not cleared: a run step only uses slots already written.
// The input is taken only while no tick is running and the result register is
// empty or being drained, so a stalled result holds the input back.
`default_nettype none

module round_robin_quantum_scheduler_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_kind,
    input  wire logic [rrqs_pkg::TICK_W-1:0] i_burst_ticks,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_added,
    output logic [rrqs_pkg::ID_W-1:0]        o_assigned_id,
    output logic                             o_ran,
    output logic [rrqs_pkg::ID_W-1:0]        o_run_id,
    output logic                             o_run_finished,
    output logic                             o_pending,
    input  wire logic                        i_cfg_we,
    input  wire logic [rrqs_pkg::TICK_W-1:0] i_cfg_wdata
);
    import rrqs_pkg::*;

    // The controller sequences each word; the datapath owns all job state.
    t_cmd cmd;
    t_sts sts;

    rrqs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath finds the next unfinished slot on acceptance, reads its
    // remaining ticks, and in the following cycle charges one tick, updates
    // the slice counter and advances the pointer when the turn ends.
    rrqs_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_kind),
        .i_burst_ticks  (i_burst_ticks),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_added        (o_added),
        .o_assigned_id  (o_assigned_id),
        .o_ran          (o_ran),
        .o_run_id       (o_run_id),
        .o_run_finished (o_run_finished),
        .o_pending      (o_pending)
    );

endmodule

`default_nettype wire
